// ===== hdl/wav_header_parser_core_macros.svh =====
// Assertion macros used by the WAV header parser checker.
`ifndef WAV_HEADER_PARSER_CORE_MACROS_SVH
`define WAV_HEADER_PARSER_CORE_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define WAVHP_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wav header parser check failed");

// Next-cycle implication, masked while reset is high.
`define WAVHP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wav header parser check failed");

// Next-cycle implication that also covers the reset cycles.
`define WAVHP_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("wav header parser check failed");

`endif

// ===== hdl/wavhp_pkg.sv =====
// Types and constants shared by the WAV header parser modules.
package wavhp_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   localparam logic [31:0] FMT_BASE_LEN    = 32'd16;
   localparam logic [7:0]  MAX_TRIES_RESET = 8'd40;
   localparam logic [15:0] COMP_PCM        = 16'd1;

   typedef enum logic [3:0] {
      PH_RIFF,
      PH_RSIZE,
      PH_WAVE,
      PH_FMT,
      PH_FSIZE,
      PH_COMP,
      PH_SRATE,
      PH_BRATE,
      PH_ALIGN,
      PH_SKIP,
      PH_TAG,
      PH_CSIZE,
      PH_DSIZE,
      PH_PAYLOAD,
      PH_HALT
   } wavhp_phase_type;

   typedef enum logic [1:0] {
      EV_HEADER  = 2'd0,
      EV_PAYLOAD = 2'd1,
      EV_ERROR   = 2'd2,
      EV_IGNORED = 2'd3
   } wavhp_event_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_NOT_RIFF  = 3'd1,
      ERR_NOT_WAVE  = 3'd2,
      ERR_NOT_FMT   = 3'd3,
      ERR_NOT_PCM   = 3'd4,
      ERR_NO_DATA   = 3'd5,
      ERR_FMT_SHORT = 3'd6
   } wavhp_error_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       file_start;
   } wavhp_item_type;

   typedef struct packed {
      logic           valid;
      wavhp_item_type item;
   } wavhp_head_type;

endpackage

// ===== hdl/wavhp_queue.sv =====
// Front end: accepts input transactions into a short FIFO.
module wavhp_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   output logic                     push_ready,
   input  wavhp_pkg::wavhp_item_type push_item,
   input  logic                     pop_en,
   output wavhp_pkg::wavhp_head_type head
);

   wavhp_pkg::wavhp_item_type               entry_ff [wavhp_pkg::QUEUE_DEPTH];
   logic [wavhp_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [wavhp_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [wavhp_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                              push;
   logic                              pop;

   localparam logic [wavhp_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
      wavhp_pkg::QUEUE_PTR_W'(wavhp_pkg::QUEUE_DEPTH - 1);
   localparam logic [wavhp_pkg::QUEUE_CNT_W-1:0] FULL_CNT =
      wavhp_pkg::QUEUE_CNT_W'(wavhp_pkg::QUEUE_DEPTH);

   assign push_ready = (count_ff != FULL_CNT);
   assign push       = push_valid && push_ready;
   assign pop        = pop_en && head.valid;

   assign head.valid = (count_ff != '0);
   assign head.item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== hdl/wavhp_engine.sv =====
// Back end: header parsing state machine and result register.
module wavhp_engine (
   input  logic                      clock,
   input  logic                      reset,
   input  wavhp_pkg::wavhp_head_type head,
   output logic                      pop_en,
   input  logic                      csr_write_en,
   input  logic [7:0]                csr_write_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_event_res,
   output logic [2:0]                rsp_error_code,
   output logic [7:0]                rsp_payload_byte,
   output logic                      rsp_last_payload,
   output logic [15:0]               rsp_channels,
   output logic [31:0]               rsp_sample_rate,
   output logic [31:0]               rsp_byte_rate,
   output logic [15:0]               rsp_block_align,
   output logic [15:0]               rsp_bits_per_sample,
   output logic [31:0]               rsp_data_size,
   output logic [31:0]               rsp_riff_size
);

   wavhp_pkg::wavhp_phase_type phase_ff, phase_in;
   wavhp_pkg::wavhp_error_type err_ff, err_in;
   wavhp_pkg::wavhp_event_type ev_ff, ev_in;
   logic [1:0]  bif_ff, bif_in;
   logic [31:0] shift_ff, shift_in;
   logic [31:0] fmt_len_ff, fmt_len_in;
   logic [31:0] skip_ff, skip_in;
   logic [7:0]  tries_ff, tries_in;
   logic [31:0] pay_rem_ff, pay_rem_in;
   logic [15:0] channels_ff, channels_in;
   logic [31:0] srate_ff, srate_in;
   logic [31:0] brate_ff, brate_in;
   logic [15:0] align_ff, align_in;
   logic [15:0] bits_ff, bits_in;
   logic [31:0] dsize_ff, dsize_in;
   logic [31:0] rsize_ff, rsize_in;
   logic [7:0]  max_tries_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  pbyte_ff, pbyte_in;
   logic        last_ff, last_in;

   logic [7:0]  in_byte;
   logic        fs;
   logic [31:0] word;
   logic [2:0]  cnt;
   wavhp_pkg::wavhp_error_type err_now;

   assign in_byte = head.item.in_byte;
   assign fs      = head.item.file_start;
   assign pop_en  = head.valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      // file start wipes the per-file state before the byte is used
      phase_in    = fs ? wavhp_pkg::PH_RIFF : phase_ff;
      err_in      = fs ? wavhp_pkg::ERR_NONE : err_ff;
      bif_in      = fs ? '0 : bif_ff;
      shift_in    = fs ? '0 : shift_ff;
      fmt_len_in  = fs ? '0 : fmt_len_ff;
      skip_in     = fs ? '0 : skip_ff;
      tries_in    = fs ? '0 : tries_ff;
      pay_rem_in  = fs ? '0 : pay_rem_ff;
      channels_in = fs ? '0 : channels_ff;
      srate_in    = fs ? '0 : srate_ff;
      brate_in    = fs ? '0 : brate_ff;
      align_in    = fs ? '0 : align_ff;
      bits_in     = fs ? '0 : bits_ff;
      dsize_in    = fs ? '0 : dsize_ff;
      rsize_in    = fs ? '0 : rsize_ff;

      ev_in    = wavhp_pkg::EV_HEADER;
      pbyte_in = '0;
      last_in  = 1'b0;
      err_now  = wavhp_pkg::ERR_NONE;
      word     = shift_in | ({24'd0, in_byte} << {bif_in, 3'b000});
      cnt      = {1'b0, bif_in} + 3'd1;

      case (phase_in)
         wavhp_pkg::PH_HALT: begin
            ev_in = wavhp_pkg::EV_IGNORED;
         end
         wavhp_pkg::PH_SKIP: begin
            if (skip_in != '0) begin
               skip_in = skip_in - 32'd1;
            end
            if (skip_in == '0) begin
               phase_in = wavhp_pkg::PH_TAG;
               bif_in   = '0;
               shift_in = '0;
            end
         end
         wavhp_pkg::PH_PAYLOAD: begin
            ev_in    = wavhp_pkg::EV_PAYLOAD;
            pbyte_in = in_byte;
            if (pay_rem_in <= 32'd1) begin
               last_in    = 1'b1;
               pay_rem_in = '0;
               phase_in   = wavhp_pkg::PH_HALT;
            end else begin
               pay_rem_in = pay_rem_in - 32'd1;
            end
         end
         default: begin
            if (phase_in == wavhp_pkg::PH_COMP && cnt == 3'd2 &&
                word[15:0] != wavhp_pkg::COMP_PCM) begin
               err_now = wavhp_pkg::ERR_NOT_PCM;
            end else if (cnt == 3'd4) begin
               bif_in   = '0;
               shift_in = '0;
               case (phase_in)
                  wavhp_pkg::PH_RIFF: begin
                     if (word != wavhp_pkg::TAG_RIFF) err_now = wavhp_pkg::ERR_NOT_RIFF;
                     else phase_in = wavhp_pkg::PH_RSIZE;
                  end
                  wavhp_pkg::PH_RSIZE: begin
                     rsize_in = word;
                     phase_in = wavhp_pkg::PH_WAVE;
                  end
                  wavhp_pkg::PH_WAVE: begin
                     if (word != wavhp_pkg::TAG_WAVE) err_now = wavhp_pkg::ERR_NOT_WAVE;
                     else phase_in = wavhp_pkg::PH_FMT;
                  end
                  wavhp_pkg::PH_FMT: begin
                     if (word != wavhp_pkg::TAG_FMT) err_now = wavhp_pkg::ERR_NOT_FMT;
                     else phase_in = wavhp_pkg::PH_FSIZE;
                  end
                  wavhp_pkg::PH_FSIZE: begin
                     fmt_len_in = word;
                     if (word < wavhp_pkg::FMT_BASE_LEN) err_now = wavhp_pkg::ERR_FMT_SHORT;
                     else phase_in = wavhp_pkg::PH_COMP;
                  end
                  wavhp_pkg::PH_COMP: begin
                     channels_in = word[31:16];
                     phase_in    = wavhp_pkg::PH_SRATE;
                  end
                  wavhp_pkg::PH_SRATE: begin
                     srate_in = word;
                     phase_in = wavhp_pkg::PH_BRATE;
                  end
                  wavhp_pkg::PH_BRATE: begin
                     brate_in = word;
                     phase_in = wavhp_pkg::PH_ALIGN;
                  end
                  wavhp_pkg::PH_ALIGN: begin
                     align_in = word[15:0];
                     bits_in  = word[31:16];
                     tries_in = max_tries_ff;
                     if (fmt_len_in > wavhp_pkg::FMT_BASE_LEN) begin
                        skip_in  = fmt_len_in - wavhp_pkg::FMT_BASE_LEN;
                        phase_in = wavhp_pkg::PH_SKIP;
                     end else begin
                        phase_in = wavhp_pkg::PH_TAG;
                     end
                  end
                  wavhp_pkg::PH_TAG: begin
                     if (word == wavhp_pkg::TAG_DATA) begin
                        phase_in = wavhp_pkg::PH_DSIZE;
                     end else if (tries_in <= 8'd1) begin
                        tries_in = '0;
                        err_now  = wavhp_pkg::ERR_NO_DATA;
                     end else begin
                        tries_in = tries_in - 8'd1;
                        phase_in = wavhp_pkg::PH_CSIZE;
                     end
                  end
                  wavhp_pkg::PH_CSIZE: begin
                     if (word == '0) begin
                        phase_in = wavhp_pkg::PH_TAG;
                     end else begin
                        skip_in  = word;
                        phase_in = wavhp_pkg::PH_SKIP;
                     end
                  end
                  default: begin
                     // data size word
                     dsize_in   = word;
                     pay_rem_in = word;
                     phase_in   = (word != '0) ? wavhp_pkg::PH_PAYLOAD : wavhp_pkg::PH_HALT;
                  end
               endcase
            end else begin
               bif_in   = cnt[1:0];
               shift_in = word;
            end
            if (err_now != wavhp_pkg::ERR_NONE) begin
               err_in   = err_now;
               phase_in = wavhp_pkg::PH_HALT;
               bif_in   = '0;
               shift_in = '0;
               ev_in    = wavhp_pkg::EV_ERROR;
            end
         end
      endcase

      rsp_valid_in = pop_en || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_tries_ff <= wavhp_pkg::MAX_TRIES_RESET;
      end else if (csr_write_en) begin
         max_tries_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= wavhp_pkg::PH_RIFF;
         err_ff       <= wavhp_pkg::ERR_NONE;
         bif_ff       <= '0;
         shift_ff     <= '0;
         fmt_len_ff   <= '0;
         skip_ff      <= '0;
         tries_ff     <= '0;
         pay_rem_ff   <= '0;
         channels_ff  <= '0;
         srate_ff     <= '0;
         brate_ff     <= '0;
         align_ff     <= '0;
         bits_ff      <= '0;
         dsize_ff     <= '0;
         rsize_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop_en) begin
            phase_ff    <= phase_in;
            err_ff      <= err_in;
            bif_ff      <= bif_in;
            shift_ff    <= shift_in;
            fmt_len_ff  <= fmt_len_in;
            skip_ff     <= skip_in;
            tries_ff    <= tries_in;
            pay_rem_ff  <= pay_rem_in;
            channels_ff <= channels_in;
            srate_ff    <= srate_in;
            brate_ff    <= brate_in;
            align_ff    <= align_in;
            bits_ff     <= bits_in;
            dsize_ff    <= dsize_in;
            rsize_ff    <= rsize_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop_en) begin
         ev_ff    <= ev_in;
         pbyte_ff <= pbyte_in;
         last_ff  <= last_in;
      end
   end

   // held fields change only when a new result is loaded, so they show directly
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_event_res       = ev_ff;
   assign rsp_error_code      = err_ff;
   assign rsp_payload_byte    = pbyte_ff;
   assign rsp_last_payload    = last_ff;
   assign rsp_channels        = channels_ff;
   assign rsp_sample_rate     = srate_ff;
   assign rsp_byte_rate       = brate_ff;
   assign rsp_block_align     = align_ff;
   assign rsp_bits_per_sample = bits_ff;
   assign rsp_data_size       = dsize_ff;
   assign rsp_riff_size       = rsize_ff;

endmodule

// ===== hdl/wav_header_parser_core.sv =====
// Top level of the WAV (RIFF/PCM) header parser.
//
// Input: one file byte per req transaction; req_file_start marks the first
// byte of a file and restarts parsing. Output: one rsp transaction per byte,
// with an event code (header byte, payload byte, error, ignored), the latched
// error code, the payload byte and last marker, and the header fields held
// so far. csr_write_en/csr_write_data set the chunk header try limit
// (reset value 40); write it only while the parser is idle.
// The accepted byte is written into the FIFO; the parse step then takes it
// from the FIFO head and loads the result register.
// Throughput: one byte per cycle while rsp_ready does not hold the result register.
// A two-entry FIFO sits between the accept side and the parser, so req_ready
// stays high while a result waits; when rsp_ready is low the result register
// holds and the FIFO fills, then req_ready drops.
// Reset (synchronous, active high) empties the FIFO, clears all header
// fields and leaves the parser expecting the RIFF tag.
module wav_header_parser_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_file_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_event_res,
   output logic [2:0]  rsp_error_code,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_last_payload,
   output logic [15:0] rsp_channels,
   output logic [31:0] rsp_sample_rate,
   output logic [31:0] rsp_byte_rate,
   output logic [15:0] rsp_block_align,
   output logic [15:0] rsp_bits_per_sample,
   output logic [31:0] rsp_data_size,
   output logic [31:0] rsp_riff_size,
   input  logic        csr_write_en,
   input  logic [7:0]  csr_write_data
);

   wavhp_pkg::wavhp_item_type req_item;
   wavhp_pkg::wavhp_head_type head;
   logic                      pop_en;

   assign req_item.in_byte    = req_in_byte;
   assign req_item.file_start = req_file_start;

   // front: transaction queue
   wavhp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_item  (req_item),
      .pop_en     (pop_en),
      .head       (head)
   );

   // back: parser and result register
   wavhp_engine u_engine (
      .clock               (clock),
      .reset               (reset),
      .head                (head),
      .pop_en              (pop_en),
      .csr_write_en        (csr_write_en),
      .csr_write_data      (csr_write_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_event_res       (rsp_event_res),
      .rsp_error_code      (rsp_error_code),
      .rsp_payload_byte    (rsp_payload_byte),
      .rsp_last_payload    (rsp_last_payload),
      .rsp_channels        (rsp_channels),
      .rsp_sample_rate     (rsp_sample_rate),
      .rsp_byte_rate       (rsp_byte_rate),
      .rsp_block_align     (rsp_block_align),
      .rsp_bits_per_sample (rsp_bits_per_sample),
      .rsp_data_size       (rsp_data_size),
      .rsp_riff_size       (rsp_riff_size)
   );

endmodule

// ===== hdl/wavhp_checker.sv =====
// Port-level checker for the WAV header parser, bound to the top level.
`include "wav_header_parser_core_macros.svh"

module wavhp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_event_res,
   input logic [2:0]  rsp_error_code,
   input logic [7:0]  rsp_payload_byte,
   input logic        rsp_last_payload
);

   `WAVHP_ASSERT_ALWAYS_NEXT(a_reset_idle, clock, reset, !rsp_valid)

   `WAVHP_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_event_res) && $stable(rsp_payload_byte))

   `WAVHP_ASSERT_IMPL(a_last_is_payload, clock, reset, rsp_valid && rsp_last_payload, rsp_event_res == wavhp_pkg::EV_PAYLOAD)

   `WAVHP_ASSERT_IMPL(a_byte_only_payload, clock, reset, rsp_valid && rsp_event_res != wavhp_pkg::EV_PAYLOAD, rsp_payload_byte == 8'd0)

   `WAVHP_ASSERT_IMPL(a_error_has_code, clock, reset, rsp_valid && rsp_event_res == wavhp_pkg::EV_ERROR, rsp_error_code != wavhp_pkg::ERR_NONE)

endmodule

bind wav_header_parser_core wavhp_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_event_res    (rsp_event_res),
   .rsp_error_code   (rsp_error_code),
   .rsp_payload_byte (rsp_payload_byte),
   .rsp_last_payload (rsp_last_payload)
);

// ===== dv/tb.sv =====
// Testbench for wav_header_parser_core: a directed table, then random WAV files checked by a parse model.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import wavhp_pkg::*;

   // ---------------------------------------------------------------------
   // Clock, reset and the block's ports
   // ---------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_in_byte = 8'h00;
   logic        req_file_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b1;
   logic [1:0]  rsp_event_res;
   logic [2:0]  rsp_error_code;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_last_payload;
   logic [15:0] rsp_channels;
   logic [31:0] rsp_sample_rate;
   logic [31:0] rsp_byte_rate;
   logic [15:0] rsp_block_align;
   logic [15:0] rsp_bits_per_sample;
   logic [31:0] rsp_data_size;
   logic [31:0] rsp_riff_size;
   logic        csr_write_en = 1'b0;
   logic [7:0]  csr_write_data = 8'h00;

   always #10 clock = ~clock;

   wav_header_parser_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_in_byte         (req_in_byte),
      .req_file_start      (req_file_start),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_event_res       (rsp_event_res),
      .rsp_error_code      (rsp_error_code),
      .rsp_payload_byte    (rsp_payload_byte),
      .rsp_last_payload    (rsp_last_payload),
      .rsp_channels        (rsp_channels),
      .rsp_sample_rate     (rsp_sample_rate),
      .rsp_byte_rate       (rsp_byte_rate),
      .rsp_block_align     (rsp_block_align),
      .rsp_bits_per_sample (rsp_bits_per_sample),
      .rsp_data_size       (rsp_data_size),
      .rsp_riff_size       (rsp_riff_size),
      .csr_write_en        (csr_write_en),
      .csr_write_data      (csr_write_data)
   );

   // ---------------------------------------------------------------------
   // Parse model: its own copy of the parser state and the try limit
   // ---------------------------------------------------------------------
   typedef struct {
      wavhp_event_type ev;
      wavhp_error_type err;
      logic [7:0]      pb;
      logic            last;
      logic [15:0]     channels;
      logic [31:0]     srate;
      logic [31:0]     brate;
      logic [15:0]     align;
      logic [15:0]     bits;
      logic [31:0]     dsize;
      logic [31:0]     rsize;
   } wav_result_t;

   wavhp_phase_type ph;
   logic [2:0]      field_pos;     // byte position inside the current 32-bit field
   logic [31:0]     shift_acc;     // little-endian assembly of that field
   logic [31:0]     fmt_len;
   logic [31:0]     skip_left;
   logic [7:0]      tries_cnt;
   logic [31:0]     payload_left;
   logic [15:0]     hold_channels, hold_align, hold_bits;
   logic [31:0]     hold_srate, hold_brate, hold_dsize, hold_rsize;
   wavhp_error_type err_latch;
   logic [7:0]      try_limit = MAX_TRIES_RESET;

   wav_result_t wav_results_q[$];   // predicted results, oldest first
   int          fault_count    = 0;
   int          accepted_count = 0;   // every accepted input transaction

   function automatic void clear_parse_state();
      ph            = PH_RIFF;
      field_pos     = '0;
      shift_acc     = '0;
      fmt_len       = '0;
      skip_left     = '0;
      tries_cnt     = '0;
      payload_left  = '0;
      hold_channels = '0;
      hold_align    = '0;
      hold_bits     = '0;
      hold_srate    = '0;
      hold_brate    = '0;
      hold_dsize    = '0;
      hold_rsize    = '0;
      err_latch     = ERR_NONE;
   endfunction

   // One byte through the parser; returns the result it produces.
   function automatic void parse_wav_byte(input logic [7:0] b, input logic start,
                                          output wav_result_t r);
      logic [31:0]     a;
      wavhp_error_type err;
      wavhp_event_type ev;
      logic [7:0]      pb;
      logic            last;
      err  = ERR_NONE;
      ev   = EV_HEADER;
      pb   = 8'h00;
      last = 1'b0;
      if (start)
         clear_parse_state();

      if (ph == PH_HALT) begin
         ev = EV_IGNORED;
      end else if (ph == PH_SKIP) begin
         if (skip_left != 0)
            skip_left = skip_left - 1;
         if (skip_left == 0) begin
            ph        = PH_TAG;
            field_pos = '0;
            shift_acc = '0;
         end
      end else if (ph == PH_PAYLOAD) begin
         ev = EV_PAYLOAD;
         pb = b;
         if (payload_left <= 1) begin
            last         = 1'b1;
            payload_left = '0;
            ph           = PH_HALT;
         end else begin
            payload_left = payload_left - 1;
         end
      end else begin
         shift_acc = shift_acc | (32'(b) << (8 * field_pos[1:0]));
         field_pos = {1'b0, field_pos[1:0]} + 3'd1;
         a         = shift_acc;
         // compression code is judged as soon as its two bytes are in
         if (ph == PH_COMP && field_pos == 3'd2 && a[15:0] != COMP_PCM) begin
            err = ERR_NOT_PCM;
         end else if (field_pos == 3'd4) begin
            field_pos = '0;
            shift_acc = '0;
            case (ph)
               PH_RIFF: begin
                  if (a != TAG_RIFF) err = ERR_NOT_RIFF;
                  else ph = PH_RSIZE;
               end
               PH_RSIZE: begin
                  hold_rsize = a;
                  ph         = PH_WAVE;
               end
               PH_WAVE: begin
                  if (a != TAG_WAVE) err = ERR_NOT_WAVE;
                  else ph = PH_FMT;
               end
               PH_FMT: begin
                  if (a != TAG_FMT) err = ERR_NOT_FMT;
                  else ph = PH_FSIZE;
               end
               PH_FSIZE: begin
                  fmt_len = a;
                  if (a < FMT_BASE_LEN) err = ERR_FMT_SHORT;
                  else ph = PH_COMP;
               end
               PH_COMP: begin
                  hold_channels = a[31:16];
                  ph            = PH_SRATE;
               end
               PH_SRATE: begin
                  hold_srate = a;
                  ph         = PH_BRATE;
               end
               PH_BRATE: begin
                  hold_brate = a;
                  ph         = PH_ALIGN;
               end
               PH_ALIGN: begin
                  hold_align = a[15:0];
                  hold_bits  = a[31:16];
                  tries_cnt  = try_limit;
                  if (fmt_len > FMT_BASE_LEN) begin
                     skip_left = fmt_len - FMT_BASE_LEN;
                     ph        = PH_SKIP;
                  end else begin
                     ph = PH_TAG;
                  end
               end
               PH_TAG: begin
                  // a limit of zero behaves like one
                  if (a == TAG_DATA) begin
                     ph = PH_DSIZE;
                  end else if (tries_cnt <= 8'd1) begin
                     tries_cnt = '0;
                     err       = ERR_NO_DATA;
                  end else begin
                     tries_cnt = tries_cnt - 8'd1;
                     ph        = PH_CSIZE;
                  end
               end
               PH_CSIZE: begin
                  if (a == 0) begin
                     ph = PH_TAG;
                  end else begin
                     skip_left = a;
                     ph        = PH_SKIP;
                  end
               end
               PH_DSIZE: begin
                  hold_dsize   = a;
                  payload_left = a;
                  ph           = (a != 0) ? PH_PAYLOAD : PH_HALT;
               end
               default: ;
            endcase
         end
         if (err != ERR_NONE) begin
            err_latch = err;
            ph        = PH_HALT;
            field_pos = '0;
            shift_acc = '0;
            ev        = EV_ERROR;
         end
      end

      r.ev       = ev;
      r.err      = err_latch;
      r.pb       = pb;
      r.last     = last;
      r.channels = hold_channels;
      r.srate    = hold_srate;
      r.brate    = hold_brate;
      r.align    = hold_align;
      r.bits     = hold_bits;
      r.dsize    = hold_dsize;
      r.rsize    = hold_rsize;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (want_v !== got_v) begin
         $error("%s: expected %0h, actual %0h", name, want_v, got_v);
         fault_count++;
      end
   endtask

   // ---------------------------------------------------------------------
   // Monitor: everything is sampled at the rising edge.
   // Results are matched before new bytes are predicted, so a result can
   // never be matched against the prediction of its own cycle.
   // ---------------------------------------------------------------------
   logic            row_typed = 1'b0;   // directed row carries its own event and error
   wavhp_event_type row_ev    = EV_HEADER;
   wavhp_error_type row_err   = ERR_NONE;

   always @(posedge clock) begin
      wav_result_t want;
      if (reset) begin
         clear_parse_state();
         try_limit = MAX_TRIES_RESET;
         wav_results_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (wav_results_q.size() == 0) begin
               $error("result transaction with no prediction pending");
               fault_count++;
            end else begin
               want = wav_results_q.pop_front();
               check_field("event_res", want.ev, rsp_event_res);
               check_field("error_code", want.err, rsp_error_code);
               check_field("payload_byte", want.pb, rsp_payload_byte);
               check_field("last_payload", want.last, rsp_last_payload);
               check_field("channels", want.channels, rsp_channels);
               check_field("sample_rate", want.srate, rsp_sample_rate);
               check_field("byte_rate", want.brate, rsp_byte_rate);
               check_field("block_align", want.align, rsp_block_align);
               check_field("bits_per_sample", want.bits, rsp_bits_per_sample);
               check_field("data_size", want.dsize, rsp_data_size);
               check_field("riff_size", want.rsize, rsp_riff_size);
            end
         end
         if (req_valid && req_ready) begin
            parse_wav_byte(req_in_byte, req_file_start, want);
            if (row_typed) begin
               want.ev  = row_ev;
               want.err = row_err;
            end
            accepted_count++;
            wav_results_q.push_back(want);
         end
         // register writes land at this edge, only ever while idle
         if (csr_write_en)
            try_limit = csr_write_data;
      end
   end

   // ---------------------------------------------------------------------
   // Result side back-pressure: bursts of stalled cycles, with quiet
   // stretches; none at all once the run is calm.
   // ---------------------------------------------------------------------
   logic calm        = 1'b0;
   logic sink_bursty = 1'b1;
   logic src_bursty  = 1'b1;
   int   sink_stall_left = 0;

   always @(negedge clock) begin
      if (reset || calm) begin
         rsp_ready <= 1'b1;
      end else if (sink_stall_left != 0) begin
         rsp_ready       <= 1'b0;
         sink_stall_left <= sink_stall_left - 1;
      end else if (sink_bursty && $urandom_range(0, 5) == 0) begin
         rsp_ready       <= 1'b0;
         sink_stall_left <= $urandom_range(0, 4);
      end else begin
         rsp_ready <= 1'b1;
      end
      if ($urandom_range(0, 99) == 0)
         sink_bursty <= !sink_bursty;
   end

   // ---------------------------------------------------------------------
   // Sender. Every task is entered and left at a falling edge.
   // ---------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] data, input logic start, input logic typed,
                            input wavhp_event_type ev, input wavhp_error_type err);
      if ($urandom_range(0, 49) == 0)
         src_bursty = !src_bursty;
      if (!calm && src_bursty && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_in_byte    <= data;
      req_file_start <= start;
      row_typed      <= typed;
      row_ev         <= ev;
      row_err        <= err;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Hold off until every predicted result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      row_typed <= 1'b0;
      while (wav_results_q.size() != 0)
         @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_try_limit(input logic [7:0] value);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_en   <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // WAV file builder
   // ---------------------------------------------------------------------
   logic [7:0] file_q[$];

   function automatic void push_word(input logic [31:0] w);
      for (int i = 0; i < 4; i++)
         file_q.push_back(w[8*i +: 8]);
   endfunction

   function automatic void push_half(input logic [15:0] h);
      file_q.push_back(h[7:0]);
      file_q.push_back(h[15:8]);
   endfunction

   function automatic void push_noise(input int n);
      for (int i = 0; i < n; i++)
         file_q.push_back(8'($urandom));
   endfunction

   // Scenario kinds
   localparam int K_ZEROS    = 0;   // well formed, riff size and fmt fields all zero
   localparam int K_CHUNKS   = 1;   // longer fmt plus foreign chunks before data
   localparam int K_EMPTY    = 2;   // data size zero, no payload
   localparam int K_NOT_PCM  = 3;
   localparam int K_SHORT    = 4;   // fmt size below 16
   localparam int K_EXHAUST  = 5;   // as many foreign chunks as the try limit, at most 12
   localparam int K_BAD_TAG  = 6;   // one byte of RIFF, WAVE or fmt corrupted
   localparam int K_NOISE    = 7;   // random bytes only
   localparam int K_CUT      = 8;   // random sizes, cut off by the next file
   localparam int K_ONES     = 9;   // all header fields at their top value, cut off
   localparam int K_COUNT    = 10;

   task automatic build_file(input int kind);
      logic [31:0] riff_tag, wave_tag, fmt_tag, mask;
      logic [31:0] riff_sz, srate, brate, flen, dsize, ctag;
      logic [15:0] chans, comp, align, bits;
      int          nchunks, nskip, npay, eff, csize, cut, trail, cut_len;
      file_q.delete();
      if (kind == K_NOISE) begin
         push_noise($urandom_range(4, 16));
         return;
      end
      riff_tag = TAG_RIFF;
      wave_tag = TAG_WAVE;
      fmt_tag  = TAG_FMT;
      riff_sz  = $urandom;
      chans    = 16'($urandom);
      srate    = $urandom;
      brate    = $urandom;
      align    = 16'($urandom);
      bits     = 16'($urandom);
      comp     = COMP_PCM;
      flen     = FMT_BASE_LEN;
      dsize    = $urandom_range(1, 24);
      nchunks  = 0;
      cut      = 0;
      trail    = $urandom_range(0, 3);
      eff      = (try_limit == 0) ? 1 : int'(try_limit);
      case (kind)
         K_ZEROS: begin
            riff_sz = '0; chans = '0; srate = '0; brate = '0; align = '0; bits = '0;
         end
         K_CHUNKS: begin
            flen    = FMT_BASE_LEN + $urandom_range(1, 8);
            nchunks = $urandom_range(1, 3);
         end
         K_EMPTY:   dsize = '0;
         K_NOT_PCM: begin
            comp = 16'($urandom);
            if (comp == COMP_PCM)
               comp = 16'h0101;     // right low byte, wrong high byte
         end
         K_SHORT:   flen = $urandom_range(0, 15);
         K_EXHAUST: nchunks = (eff <= 12) ? eff : 12;
         K_BAD_TAG: begin
            mask = 32'(8'($urandom_range(1, 255))) << (8 * $urandom_range(0, 3));
            case ($urandom_range(0, 2))
               0:       riff_tag = riff_tag ^ mask;
               1:       wave_tag = wave_tag ^ mask;
               default: fmt_tag  = fmt_tag ^ mask;
            endcase
         end
         K_CUT: begin
            flen    = $urandom;
            if (flen < FMT_BASE_LEN)
               flen = FMT_BASE_LEN;
            dsize   = $urandom;
            nchunks = $urandom_range(0, 2);
            cut     = 1;
         end
         K_ONES: begin
            riff_sz = '1; chans = '1; srate = '1; brate = '1; align = '1; bits = '1;
            dsize   = '1;
            cut     = 1;
         end
         default: ;
      endcase

      push_word(riff_tag);
      push_word(riff_sz);
      push_word(wave_tag);
      push_word(fmt_tag);
      push_word(flen);
      push_half(comp);
      push_half(chans);
      push_word(srate);
      push_word(brate);
      push_half(align);
      push_half(bits);
      nskip = (flen > FMT_BASE_LEN) ?
              ((flen - FMT_BASE_LEN > 24) ? 24 : int'(flen - FMT_BASE_LEN)) : 0;
      push_noise(nskip);
      for (int c = 0; c < nchunks; c++) begin
         ctag = $urandom;
         if (ctag == TAG_DATA)
            ctag = ctag ^ 32'h1;
         csize = $urandom_range(0, 9);   // zero and odd sizes included
         push_word(ctag);
         push_word(csize);
         push_noise(csize);
      end
      push_word(TAG_DATA);
      push_word(dsize);
      npay = (dsize > 24) ? 24 : int'(dsize);
      push_noise(npay);
      if (cut != 0) begin
         cut_len = $urandom_range(1, file_q.size() - 1);
         while (file_q.size() > cut_len)
            void'(file_q.pop_back());
      end
      push_noise(trail);   // trailing bytes without a file start
   endtask

   task automatic send_file();
      foreach (file_q[i])
         send_byte(file_q[i], (i == 0), 1'b0, EV_HEADER, ERR_NONE);
   endtask

   // ---------------------------------------------------------------------
   // Directed table. Event and error are typed in where they are obvious;
   // every other field comes from the parse model.
   // ---------------------------------------------------------------------
   typedef struct {
      logic [7:0]      data;
      logic            start;
      logic            typed;
      wavhp_event_type ev;
      wavhp_error_type err;
   } directed_row_t;

   directed_row_t directed_tab [25] = '{
      // straight after reset, no file start: RIFF already expected
      '{8'h52, 1'b0, 1'b1, EV_HEADER,  ERR_NONE},
      '{8'h49, 1'b0, 1'b0, EV_HEADER,  ERR_NONE},
      '{8'h46, 1'b0, 1'b0, EV_HEADER,  ERR_NONE},
      '{8'h46, 1'b0, 1'b1, EV_HEADER,  ERR_NONE},
      // riff size with byte extremes
      '{8'h00, 1'b0, 1'b0, EV_HEADER,  ERR_NONE},
      '{8'hFF, 1'b0, 1'b0, EV_HEADER,  ERR_NONE},
      '{8'h00, 1'b0, 1'b0, EV_HEADER,  ERR_NONE},
      '{8'hFF, 1'b0, 1'b0, EV_HEADER,  ERR_NONE},
      // "WAVX": error on the fourth tag byte, then ignored until a new file
      '{8'h57, 1'b0, 1'b0, EV_HEADER,  ERR_NONE},
      '{8'h41, 1'b0, 1'b0, EV_HEADER,  ERR_NONE},
      '{8'h56, 1'b0, 1'b0, EV_HEADER,  ERR_NONE},
      '{8'h58, 1'b0, 1'b1, EV_ERROR,   ERR_NOT_WAVE},
      '{8'h00, 1'b0, 1'b1, EV_IGNORED, ERR_NOT_WAVE},
      '{8'hFF, 1'b0, 1'b1, EV_IGNORED, ERR_NOT_WAVE},
      // file start clears the error; "RIF" + 0xFF is not RIFF
      '{8'h52, 1'b1, 1'b1, EV_HEADER,  ERR_NONE},
      '{8'h49, 1'b0, 1'b0, EV_HEADER,  ERR_NONE},
      '{8'h46, 1'b0, 1'b0, EV_HEADER,  ERR_NONE},
      '{8'hFF, 1'b0, 1'b1, EV_ERROR,   ERR_NOT_RIFF},
      '{8'hA5, 1'b0, 1'b1, EV_IGNORED, ERR_NOT_RIFF},
      // restarts in the middle of a tag
      '{8'h00, 1'b1, 1'b1, EV_HEADER,  ERR_NONE},
      '{8'hFF, 1'b1, 1'b1, EV_HEADER,  ERR_NONE},
      '{8'h52, 1'b1, 1'b0, EV_HEADER,  ERR_NONE},
      '{8'h49, 1'b0, 1'b0, EV_HEADER,  ERR_NONE},
      '{8'h46, 1'b0, 1'b0, EV_HEADER,  ERR_NONE},
      '{8'h46, 1'b0, 1'b1, EV_HEADER,  ERR_NONE}
   };

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      int limit_val;
      int target;
      int kind;
      int file_idx;
      int files_in_phase;
      file_idx = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_tab[i])
         send_byte(directed_tab[i].data, directed_tab[i].start, directed_tab[i].typed,
                   directed_tab[i].ev, directed_tab[i].err);
      // sender waits here for every outstanding result
      drain_results();

      // phase 0 keeps the reset limit; the rest go through the extremes
      for (int phase = 0; phase < 6; phase++) begin
         if (phase > 0) begin
            case (phase)
               1:       limit_val = 255;
               2:       limit_val = 1;
               3:       limit_val = 0;
               4:       limit_val = 3;
               default: limit_val = $urandom_range(2, 12);
            endcase
            write_try_limit(8'(limit_val));
         end
         if (phase == 5)
            calm = 1'b1;   // no idling on either side from here on
         target         = accepted_count + 160;
         files_in_phase = 0;
         while (accepted_count < target) begin
            if (files_in_phase == 0 && (try_limit == 0 || try_limit <= 12))
               kind = K_EXHAUST;
            else if (file_idx < K_COUNT)
               kind = file_idx;
            else begin
               // mostly well formed files, the rest broken or noise
               case ($urandom_range(0, 15))
                  0, 1, 2, 3, 4, 5: kind = K_CHUNKS;
                  6, 7:             kind = K_ZEROS;
                  8:                kind = K_EMPTY;
                  9:                kind = K_NOT_PCM;
                  10:               kind = K_SHORT;
                  11:               kind = K_EXHAUST;
                  12:               kind = K_BAD_TAG;
                  13:               kind = K_NOISE;
                  14:               kind = K_CUT;
                  default:          kind = K_ONES;
               endcase
            end
            build_file(kind);
            send_file();
            file_idx++;
            files_in_phase++;
         end
         drain_results();
      end

      repeat (8) @(negedge clock);
      if (fault_count == 0)
         $display("wav_header_parser_core verification clean");
      else
         $display("wav_header_parser_core verification failed");
      $finish;
   end

   // Watchdog, far above the slowest legal run.
   initial begin
      #10_000_000;
      $display("wav_header_parser_core verification failed");
      $finish;
   end

endmodule
